// File: rtl/dsaq_pkg.sv
// ----------------------------------------------------------------------------
// dsaq_pkg
// Shared codes, state encoding and the command/status bundles that join the
// alarm queue controller and datapath.
// ----------------------------------------------------------------------------
package dsaq_pkg;

  // operation codes on in_operation
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_KILL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_EXPIRED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_KILLED   = 3'd3,
    ST_MISSING  = 3'd4,
    ST_FIRED    = 3'd5,
    ST_NONE_DUE = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_START,
    S_A_SCAN,
    S_A_PUT,
    S_A_DONE,
    S_K_START,
    S_K_SCAN,
    S_K_SHIFT,
    S_K_DONE,
    S_T_START,
    S_T_FIRE
  } state_t;

  // logical read offset, relative to the ring base
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_ONE,
    RD_TWO,
    RD_CNT_M1,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_IDX_P2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WO_ZERO,
    WO_IDX,
    WO_IDX_P1
  } wr_off_t;

  typedef enum logic {
    WS_RD,
    WS_NEW
  } wr_src_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_CNT_M1,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    HEAD_HOLD,
    HEAD_NEW,
    HEAD_RD
  } head_op_t;

  typedef struct packed {
    logic     latch;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_off_t  wr_off;
    wr_src_t  wr_src;
    idx_op_t  idx_op;
    cnt_op_t  cnt_op;
    logic     base_inc;
    head_op_t head_op;
    logic     emit;
    logic     emit_fire;
    status_t  emit_status;
  } cmd_t;

  typedef struct packed {
    logic expired;
    logic full;
    logic empty;
    logic head_due;
    logic rd_ge_trig;
    logic key_match;
    logic idx_zero;
    logic idx_last;
    logic shift_end;
    logic next_last;
  } sts_t;

endpackage

// File: rtl/deadline_sorted_alarm_queue_top.sv
// Results: add and kill give one result each, tick one if nothing is due, else
//   one fired result per due entry, back to back; results cannot be stalled.
// Throughput: one transaction at a time, one table entry per cycle; the next
//   start is taken at the earliest on the edge of the last result.
// Reset (rst_n low, synchronous) empties the table and returns to idle.
// ----------------------------------------------------------------------------
// deadline_sorted_alarm_queue_top
// Bounded table of pending alarms kept in deadline order, with add, kill by
// key and tick (fire everything due) transactions.
// ----------------------------------------------------------------------------
module deadline_sorted_alarm_queue_top #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command side: a transaction is taken when start is high and busy is low
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_operation,
  input  logic [TIME_BITS-1:0]       in_now,
  input  logic [TIME_BITS-1:0]       in_trigger_time,
  input  logic [KEY_BITS-1:0]        in_alarm_key,
  // result side: one result per cycle while out_valid is high
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [TIME_BITS-1:0]       out_fired_time,
  output logic [KEY_BITS-1:0]        out_fired_key,
  output logic                       out_last,
  output logic [$clog2(DEPTH+1)-1:0] out_pending_count,
  output logic [TIME_BITS-1:0]       out_head_time
);

  // The table lives in a ring: logical slot 0 (the earliest deadline) sits at
  // the base pointer, so firing the head is just advance base, drop count.
  // Add walks down from the tail shifting later deadlines up one slot; kill
  // scans from the head for the first key match and closes the gap.
  // A copy of the head entry is held in a register so results other than fires
  // can report the head deadline without another memory read.

  dsaq_pkg::cmd_t cmd;
  dsaq_pkg::sts_t sts;

  dsaq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  dsaq_dp #(
    .DEPTH     (DEPTH),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_now            (in_now),
    .in_trigger_time   (in_trigger_time),
    .in_alarm_key      (in_alarm_key),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_fired_time    (out_fired_time),
    .out_fired_key     (out_fired_key),
    .out_last          (out_last),
    .out_pending_count (out_pending_count),
    .out_head_time     (out_head_time)
  );

endmodule

// File: rtl/dsaq_ctrl.sv
// ----------------------------------------------------------------------------
// dsaq_ctrl
// Sequencer for the alarm queue: walks add, kill and tick transactions one
// table entry per cycle and drives datapath commands.
// ----------------------------------------------------------------------------
module dsaq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_operation,
  input  dsaq_pkg::sts_t sts,
  output dsaq_pkg::cmd_t cmd,
  output logic          busy
);

  dsaq_pkg::state_t state_r;
  dsaq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsaq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != dsaq_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsaq_pkg::S_IDLE: begin
        if (start) begin
          case (in_operation)
            dsaq_pkg::OP_ADD:  state_nxt = dsaq_pkg::S_A_START;
            dsaq_pkg::OP_KILL: state_nxt = dsaq_pkg::S_K_START;
            dsaq_pkg::OP_TICK: state_nxt = dsaq_pkg::S_T_START;
            default:           state_nxt = dsaq_pkg::S_IDLE;
          endcase
        end
      end
      dsaq_pkg::S_A_START: begin
        if (sts.expired || sts.full) state_nxt = dsaq_pkg::S_IDLE;
        else if (sts.empty)          state_nxt = dsaq_pkg::S_A_DONE;
        else                         state_nxt = dsaq_pkg::S_A_SCAN;
      end
      dsaq_pkg::S_A_SCAN: begin
        if (!sts.rd_ge_trig)   state_nxt = dsaq_pkg::S_A_DONE;
        else if (sts.idx_zero) state_nxt = dsaq_pkg::S_A_PUT;
      end
      dsaq_pkg::S_A_PUT:   state_nxt = dsaq_pkg::S_A_DONE;
      dsaq_pkg::S_A_DONE:  state_nxt = dsaq_pkg::S_IDLE;
      dsaq_pkg::S_K_START: begin
        state_nxt = sts.empty ? dsaq_pkg::S_IDLE : dsaq_pkg::S_K_SCAN;
      end
      dsaq_pkg::S_K_SCAN: begin
        if (sts.key_match) begin
          state_nxt = sts.idx_last ? dsaq_pkg::S_K_DONE : dsaq_pkg::S_K_SHIFT;
        end else if (sts.idx_last) begin
          state_nxt = dsaq_pkg::S_IDLE;
        end
      end
      dsaq_pkg::S_K_SHIFT: begin
        if (sts.shift_end) state_nxt = dsaq_pkg::S_K_DONE;
      end
      dsaq_pkg::S_K_DONE:  state_nxt = dsaq_pkg::S_IDLE;
      dsaq_pkg::S_T_START: begin
        state_nxt = sts.head_due ? dsaq_pkg::S_T_FIRE : dsaq_pkg::S_IDLE;
      end
      dsaq_pkg::S_T_FIRE: begin
        if (sts.next_last) state_nxt = dsaq_pkg::S_IDLE;
      end
      default: state_nxt = dsaq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      dsaq_pkg::S_IDLE: begin
        cmd.latch = start;
      end
      dsaq_pkg::S_A_START: begin
        if (sts.expired) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = dsaq_pkg::ST_EXPIRED;
        end else if (sts.full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = dsaq_pkg::ST_FULL;
        end else if (sts.empty) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_off  = dsaq_pkg::WO_ZERO;
          cmd.wr_src  = dsaq_pkg::WS_NEW;
          cmd.head_op = dsaq_pkg::HEAD_NEW;
          cmd.cnt_op  = dsaq_pkg::CNT_INC;
        end else begin
          cmd.rd_sel = dsaq_pkg::RD_CNT_M1;
          cmd.idx_op = dsaq_pkg::IDX_CNT_M1;
        end
      end
      dsaq_pkg::S_A_SCAN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_off = dsaq_pkg::WO_IDX_P1;
        if (sts.rd_ge_trig) begin
          // move this entry up one slot, keep walking down unless at slot 0
          cmd.wr_src = dsaq_pkg::WS_RD;
          if (!sts.idx_zero) begin
            cmd.rd_sel = dsaq_pkg::RD_IDX_M1;
            cmd.idx_op = dsaq_pkg::IDX_DEC;
          end
        end else begin
          cmd.wr_src = dsaq_pkg::WS_NEW;
          cmd.cnt_op = dsaq_pkg::CNT_INC;
        end
      end
      dsaq_pkg::S_A_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_off  = dsaq_pkg::WO_ZERO;
        cmd.wr_src  = dsaq_pkg::WS_NEW;
        cmd.head_op = dsaq_pkg::HEAD_NEW;
        cmd.cnt_op  = dsaq_pkg::CNT_INC;
      end
      dsaq_pkg::S_A_DONE: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = dsaq_pkg::ST_ADDED;
      end
      dsaq_pkg::S_K_START: begin
        if (sts.empty) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = dsaq_pkg::ST_MISSING;
        end else begin
          cmd.rd_sel = dsaq_pkg::RD_ZERO;
          cmd.idx_op = dsaq_pkg::IDX_ZERO;
        end
      end
      dsaq_pkg::S_K_SCAN: begin
        cmd.rd_sel = dsaq_pkg::RD_IDX_P1;
        if (sts.key_match) begin
          if (sts.idx_last) cmd.cnt_op = dsaq_pkg::CNT_DEC;
        end else begin
          cmd.idx_op = dsaq_pkg::IDX_INC;
          if (sts.idx_last) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = dsaq_pkg::ST_MISSING;
          end
        end
      end
      dsaq_pkg::S_K_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_off = dsaq_pkg::WO_IDX;
        cmd.wr_src = dsaq_pkg::WS_RD;
        if (sts.idx_zero) cmd.head_op = dsaq_pkg::HEAD_RD;
        if (sts.shift_end) begin
          cmd.cnt_op = dsaq_pkg::CNT_DEC;
        end else begin
          cmd.rd_sel = dsaq_pkg::RD_IDX_P2;
          cmd.idx_op = dsaq_pkg::IDX_INC;
        end
      end
      dsaq_pkg::S_K_DONE: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = dsaq_pkg::ST_KILLED;
      end
      dsaq_pkg::S_T_START: begin
        if (sts.head_due) begin
          cmd.rd_sel = dsaq_pkg::RD_ONE;
        end else begin
          cmd.emit        = 1'b1;
          cmd.emit_status = dsaq_pkg::ST_NONE_DUE;
        end
      end
      dsaq_pkg::S_T_FIRE: begin
        cmd.emit        = 1'b1;
        cmd.emit_fire   = 1'b1;
        cmd.emit_status = dsaq_pkg::ST_FIRED;
        cmd.cnt_op      = dsaq_pkg::CNT_DEC;
        cmd.base_inc    = 1'b1;
        cmd.head_op     = dsaq_pkg::HEAD_RD;
        cmd.rd_sel      = dsaq_pkg::RD_TWO;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/dsaq_dp.sv
// ----------------------------------------------------------------------------
// dsaq_dp
// Alarm table datapath: ring-addressed entry memory, count, base, head copy,
// scan index, input latches and the registered result port.
// ----------------------------------------------------------------------------
module dsaq_dp #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [TIME_BITS-1:0]           in_now,
  input  logic [TIME_BITS-1:0]           in_trigger_time,
  input  logic [KEY_BITS-1:0]            in_alarm_key,
  input  dsaq_pkg::cmd_t                 cmd,
  output dsaq_pkg::sts_t                 sts,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [TIME_BITS-1:0]           out_fired_time,
  output logic [KEY_BITS-1:0]            out_fired_key,
  output logic                           out_last,
  output logic [$clog2(DEPTH+1)-1:0]     out_pending_count,
  output logic [TIME_BITS-1:0]           out_head_time
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int EW = TIME_BITS + KEY_BITS;

  logic [EW-1:0]        mem [DEPTH];
  logic [EW-1:0]        rd_data_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] trig_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [CW-1:0]        count_r;
  logic [AW-1:0]        base_r;
  logic [CW-1:0]        idx_r;
  logic [EW-1:0]        head_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [TIME_BITS-1:0] out_fired_time_r;
  logic [KEY_BITS-1:0]  out_fired_key_r;
  logic                 out_last_r;
  logic [CW-1:0]        out_pending_r;
  logic [TIME_BITS-1:0] out_head_r;

  logic [CW-1:0]        rd_off;
  logic [CW-1:0]        wr_off;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        new_entry;
  logic [EW-1:0]        wr_data;
  logic [TIME_BITS-1:0] rd_time;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TIME_BITS-1:0] head_time;

  // logical slot to physical address around the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(o);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign new_entry = {trig_r, key_r};
  assign rd_time   = rd_data_r[EW-1:KEY_BITS];
  assign rd_key    = rd_data_r[KEY_BITS-1:0];
  assign head_time = head_r[EW-1:KEY_BITS];

  always_comb begin
    case (cmd.rd_sel)
      dsaq_pkg::RD_ZERO:   rd_off = '0;
      dsaq_pkg::RD_ONE:    rd_off = CW'(1);
      dsaq_pkg::RD_TWO:    rd_off = CW'(2);
      dsaq_pkg::RD_CNT_M1: rd_off = count_r - CW'(1);
      dsaq_pkg::RD_IDX_M1: rd_off = idx_r - CW'(1);
      dsaq_pkg::RD_IDX_P1: rd_off = idx_r + CW'(1);
      dsaq_pkg::RD_IDX_P2: rd_off = idx_r + CW'(2);
      default:             rd_off = '0;
    endcase
    case (cmd.wr_off)
      dsaq_pkg::WO_ZERO:   wr_off = '0;
      dsaq_pkg::WO_IDX:    wr_off = idx_r;
      dsaq_pkg::WO_IDX_P1: wr_off = idx_r + CW'(1);
      default:             wr_off = '0;
    endcase
  end

  assign rd_addr = phys(base_r, rd_off);
  assign wr_addr = phys(base_r, wr_off);
  assign wr_data = (cmd.wr_src == dsaq_pkg::WS_NEW) ? new_entry : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    sts.expired    = trig_r < now_r;
    sts.full       = count_r == CW'(DEPTH);
    sts.empty      = count_r == '0;
    sts.head_due   = (count_r != '0) && (head_time <= now_r);
    sts.rd_ge_trig = rd_time >= trig_r;
    sts.key_match  = rd_key == key_r;
    sts.idx_zero   = idx_r == '0;
    sts.idx_last   = ((CW+1)'(idx_r) + (CW+1)'(1)) == (CW+1)'(count_r);
    sts.shift_end  = ((CW+1)'(idx_r) + (CW+1)'(2)) == (CW+1)'(count_r);
    sts.next_last  = (count_r == CW'(1)) || (rd_time > now_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      now_r  <= in_now;
      trig_r <= in_trigger_time;
      key_r  <= in_alarm_key;
    end
    case (cmd.idx_op)
      dsaq_pkg::IDX_ZERO:   idx_r <= '0;
      dsaq_pkg::IDX_CNT_M1: idx_r <= count_r - CW'(1);
      dsaq_pkg::IDX_INC:    idx_r <= idx_r + CW'(1);
      dsaq_pkg::IDX_DEC:    idx_r <= idx_r - CW'(1);
      default:              idx_r <= idx_r;
    endcase
    case (cmd.head_op)
      dsaq_pkg::HEAD_NEW: head_r <= new_entry;
      dsaq_pkg::HEAD_RD:  head_r <= rd_data_r;
      default:            head_r <= head_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.cnt_op)
        dsaq_pkg::CNT_INC: count_r <= count_r + CW'(1);
        dsaq_pkg::CNT_DEC: count_r <= count_r - CW'(1);
        default:           count_r <= count_r;
      endcase
      if (cmd.base_inc) begin
        base_r <= (base_r == AW'(DEPTH-1)) ? '0 : base_r + AW'(1);
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      if (cmd.emit_fire) begin
        out_fired_time_r <= head_time;
        out_fired_key_r  <= head_r[KEY_BITS-1:0];
        out_last_r       <= sts.next_last;
        out_pending_r    <= count_r - CW'(1);
        out_head_r       <= (count_r > CW'(1)) ? rd_time : '0;
      end else begin
        out_fired_time_r <= '0;
        out_fired_key_r  <= '0;
        out_last_r       <= 1'b1;
        out_pending_r    <= count_r;
        out_head_r       <= (count_r != '0) ? head_time : '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_fired_time    = out_fired_time_r;
  assign out_fired_key     = out_fired_key_r;
  assign out_last          = out_last_r;
  assign out_pending_count = out_pending_r;
  assign out_head_time     = out_head_r;

endmodule

// File: rtl/dsaq_checker.sv
// ----------------------------------------------------------------------------
// dsaq_checker
// Port-level checks on the alarm queue's result stream and command side.
// ----------------------------------------------------------------------------
module dsaq_checker #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 in_operation,
  input logic                       out_valid,
  input logic [2:0]                 out_status,
  input logic [TIME_BITS-1:0]       out_fired_time,
  input logic [KEY_BITS-1:0]        out_fired_key,
  input logic                       out_last,
  input logic [$clog2(DEPTH+1)-1:0] out_pending_count,
  input logic [TIME_BITS-1:0]       out_head_time
);

  localparam int CW = $clog2(DEPTH+1);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending_count <= CW'(DEPTH))
    else $error("pending count above table depth");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pending_count == '0) |-> out_head_time == '0)
    else $error("empty table reports a head deadline");

  a_nonfire_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != dsaq_pkg::ST_FIRED) |->
      (out_fired_time == '0 && out_fired_key == '0 && out_last))
    else $error("non-fire result carries fired data or is not last");

  a_fire_not_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == dsaq_pkg::ST_FIRED && !out_last) |=>
      (out_valid && out_status == dsaq_pkg::ST_FIRED))
    else $error("fire sequence broken before its last result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == dsaq_pkg::OP_ADD ||
      in_operation == dsaq_pkg::OP_KILL || in_operation == dsaq_pkg::OP_TICK))
      |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

bind deadline_sorted_alarm_queue_top dsaq_checker #(
  .DEPTH     (DEPTH),
  .KEY_BITS  (KEY_BITS),
  .TIME_BITS (TIME_BITS)
) u_dsaq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_operation      (in_operation),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_fired_time    (out_fired_time),
  .out_fired_key     (out_fired_key),
  .out_last          (out_last),
  .out_pending_count (out_pending_count),
  .out_head_time     (out_head_time)
);

// File: bench/deadline_sorted_alarm_queue_top_tb.sv
// ----------------------------------------------------------------------------
// deadline_sorted_alarm_queue_top_tb
// Self-checking bench for the deadline-ordered alarm table. A directed run
// covers the field extremes, every operation and the table corner cases:
// expired add, full table, duplicate deadlines and keys, the unused opcode
// and a tick with nothing due. A random run then alternates fill and drain
// phases around a moving time base. A clocked driver feeds commands in
// bursts. A clocked monitor checks each result strobe against a local
// prediction of the table.
// ----------------------------------------------------------------------------
module deadline_sorted_alarm_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 16;
  localparam int KEY_BITS       = 16;
  localparam int TIME_BITS      = 32;
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int N_RANDOM       = 242;
  localparam int DRAIN_CYCLES   = 2 * (DEPTH + 4);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // opcode that the block has to ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]           operation;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] trigger_time;
    logic [KEY_BITS-1:0]  alarm_key;
  } alarm_cmd_t;

  typedef struct packed {
    dsaq_pkg::status_t    status;
    logic [TIME_BITS-1:0] fired_time;
    logic [KEY_BITS-1:0]  fired_key;
    logic                 last;
    logic [CNT_W-1:0]     pending_count;
    logic [TIME_BITS-1:0] head_time;
  } alarm_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  alarm_cmd_t drv_cmd = '0;

  logic                 out_valid;
  logic [2:0]           out_status;
  logic [TIME_BITS-1:0] out_fired_time;
  logic [KEY_BITS-1:0]  out_fired_key;
  logic                 out_last;
  logic [CNT_W-1:0]     out_pending_count;
  logic [TIME_BITS-1:0] out_head_time;

  // commands waiting for the driver, and results owed by the block
  alarm_cmd_t cmd_q[$];
  alarm_res_t owed_q[$];

  // predicted alarm table, kept sorted by deadline
  logic [TIME_BITS-1:0] tbl_deadline[DEPTH];
  logic [KEY_BITS-1:0]  tbl_key[DEPTH];
  int                   tbl_count = 0;

  int err_count  = 0;
  int idle_count = 0;
  int burst_left = 1;
  int gap_left   = 0;

  always #4 clk = ~clk;

  deadline_sorted_alarm_queue_top #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TIME_BITS(TIME_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (drv_cmd.operation),
    .in_now           (drv_cmd.now),
    .in_trigger_time  (drv_cmd.trigger_time),
    .in_alarm_key     (drv_cmd.alarm_key),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_fired_time   (out_fired_time),
    .out_fired_key    (out_fired_key),
    .out_last         (out_last),
    .out_pending_count(out_pending_count),
    .out_head_time    (out_head_time)
  );

  // --------------------------------------------------------------------------
  // Table prediction
  // --------------------------------------------------------------------------

  // Queue one owed result; count and head reflect the table after it.
  function automatic void owe_result(dsaq_pkg::status_t st, logic [TIME_BITS-1:0] ft,
                                     logic [KEY_BITS-1:0] fk, logic lst);
    alarm_res_t r;
    r.status        = st;
    r.fired_time    = ft;
    r.fired_key     = fk;
    r.last          = lst;
    r.pending_count = tbl_count[CNT_W-1:0];
    r.head_time     = (tbl_count > 0) ? tbl_deadline[0] : '0;
    owed_q.push_back(r);
  endfunction

  // Drop one entry and close the hole behind it.
  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < tbl_count; i++) begin
      tbl_deadline[i] = tbl_deadline[i + 1];
      tbl_key[i]      = tbl_key[i + 1];
    end
    tbl_count--;
  endfunction

  // Apply one accepted transaction to the table and owe its results.
  function automatic void apply_alarm_cmd(alarm_cmd_t cmd);
    int                   pos;
    int                   i;
    logic [TIME_BITS-1:0] ft;
    logic [KEY_BITS-1:0]  fk;
    logic                 lst;
    int                   n_fired;
    case (cmd.operation)
      dsaq_pkg::OP_ADD: begin
        // expiry is tested ahead of the full check
        if (cmd.trigger_time < cmd.now) begin
          owe_result(dsaq_pkg::ST_EXPIRED, '0, '0, 1'b1);
        end else if (tbl_count >= DEPTH) begin
          owe_result(dsaq_pkg::ST_FULL, '0, '0, 1'b1);
        end else begin
          // insert ahead of every entry with the same deadline
          pos = 0;
          while (pos < tbl_count && tbl_deadline[pos] < cmd.trigger_time) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_deadline[i] = tbl_deadline[i - 1];
            tbl_key[i]      = tbl_key[i - 1];
          end
          tbl_deadline[pos] = cmd.trigger_time;
          tbl_key[pos]      = cmd.alarm_key;
          tbl_count++;
          owe_result(dsaq_pkg::ST_ADDED, '0, '0, 1'b1);
        end
      end
      dsaq_pkg::OP_KILL: begin
        // only the first matching key goes
        pos = -1;
        for (i = 0; i < tbl_count; i++) begin
          if (pos < 0 && tbl_key[i] == cmd.alarm_key) pos = i;
        end
        if (pos >= 0) begin
          drop_entry(pos);
          owe_result(dsaq_pkg::ST_KILLED, '0, '0, 1'b1);
        end else begin
          owe_result(dsaq_pkg::ST_MISSING, '0, '0, 1'b1);
        end
      end
      dsaq_pkg::OP_TICK: begin
        n_fired = 0;
        while (tbl_count > 0 && tbl_deadline[0] <= cmd.now) begin
          ft = tbl_deadline[0];
          fk = tbl_key[0];
          drop_entry(0);
          lst = (tbl_count == 0) || (tbl_deadline[0] > cmd.now);
          owe_result(dsaq_pkg::ST_FIRED, ft, fk, lst);
          n_fired++;
        end
        if (n_fired == 0) owe_result(dsaq_pkg::ST_NONE_DUE, '0, '0, 1'b1);
      end
      default: begin
        // unused opcode: table untouched, no result
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: take commands from cmd_q, present them in bursts with gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // the block took the current transaction on this edge
      if (start && !busy) apply_alarm_cmd(drv_cmd);
      // hold the command while the block is busy; otherwise pick the next
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (cmd_q.size() > 0) begin
          drv_cmd <= cmd_q.pop_front();
          start   <= 1'b1;
          if (burst_left <= 1) begin
            // mostly short bursts, now and then a long stretch without idling
            burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
            gap_left   <= $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobe is checked against the oldest owed result
  // --------------------------------------------------------------------------
  task automatic flag_error(string what, alarm_res_t want, alarm_res_t got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected: status=%0d time=%h key=%h last=%b count=%0d head=%h",
               want.status, want.fired_time, want.fired_key, want.last,
               want.pending_count, want.head_time);
      $display("  actual  : status=%0d time=%h key=%h last=%b count=%0d head=%h",
               got.status, got.fired_time, got.fired_key, got.last,
               got.pending_count, got.head_time);
    end
  endtask

  always @(posedge clk) begin
    alarm_res_t got;
    alarm_res_t want;
    if (rst_n && out_valid) begin
      got = {out_status, out_fired_time, out_fired_key, out_last,
             out_pending_count, out_head_time};
      if (owed_q.size() == 0) begin
        flag_error("result with no transaction owing one", '0, got);
      end else begin
        want = owed_q.pop_front();
        if (got !== want) flag_error("result mismatch", want, got);
      end
    end
  end

  // Stop the run if neither side moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_cmd(logic [1:0] op, logic [TIME_BITS-1:0] now,
                          logic [TIME_BITS-1:0] trig, logic [KEY_BITS-1:0] key);
    alarm_cmd_t c;
    c.operation    = op;
    c.now          = now;
    c.trigger_time = trig;
    c.alarm_key    = key;
    cmd_q.push_back(c);
  endtask

  // Draw keys from a small pool so kills and duplicates actually hit.
  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(0, 4) == 0) return KEY_BITS'($urandom_range(0, 65535));
    return KEY_BITS'($urandom_range(0, 7));
  endfunction

  initial begin
    int                   i;
    int                   pick;
    bit                   fill_phase;
    logic [TIME_BITS-1:0] base_time;

    // ---- directed run ----
    push_cmd(dsaq_pkg::OP_TICK, '0, '0, '0);                 // tick on empty table
    push_cmd(dsaq_pkg::OP_KILL, '1, '1, 16'h1234);           // kill on empty table
    push_cmd(dsaq_pkg::OP_ADD, 32'd100, 32'd99, 16'h0001);   // deadline just before now
    push_cmd(dsaq_pkg::OP_ADD, 32'd100, 32'd100, 16'h0001);  // deadline equal to now
    push_cmd(dsaq_pkg::OP_ADD, '0, '1, '1);                  // largest deadline and key
    push_cmd(dsaq_pkg::OP_ADD, '0, '0, '0);                  // smallest deadline and key
    push_cmd(dsaq_pkg::OP_ADD, 32'd100, 32'd100, 16'h0002);  // same deadline goes ahead
    push_cmd(dsaq_pkg::OP_ADD, 32'd100, 32'd200, 16'h0001);  // duplicate key
    push_cmd(dsaq_pkg::OP_KILL, '0, '0, 16'h0001);           // first match only
    push_cmd(OP_UNUSED, '1, '1, '1);                         // ignored opcode
    push_cmd(dsaq_pkg::OP_TICK, 32'd150, '0, '0);            // fire two, last on the second
    // fill the table to the brim, then hit it while full
    for (i = 0; i < DEPTH - 2; i++) begin
      push_cmd(dsaq_pkg::OP_ADD, 32'd150, TIME_BITS'(1000 + ((i * 7) % 40)),
               KEY_BITS'(32'h8000 | i));
    end
    push_cmd(dsaq_pkg::OP_ADD, 32'd150, 32'd3000, 16'h00AA);   // full table
    push_cmd(dsaq_pkg::OP_ADD, 32'd5000, 32'd4999, 16'h00AB);  // expiry wins over full
    push_cmd(dsaq_pkg::OP_TICK, '1, '0, '0);                   // fire the whole table

    // ---- random run: fill and drain phases around a moving time base ----
    base_time = $urandom_range(1000, 32'h7FFF_FFFF);
    for (i = 0; i < N_RANDOM; i++) begin
      // jump anywhere now and then, near the wrap point included
      if (i % 90 == 89) base_time = $urandom();
      fill_phase = ((i / 40) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (fill_phase ? (pick < 75) : (pick < 45)) begin
        if ($urandom_range(0, 9) == 0) begin
          push_cmd(dsaq_pkg::OP_ADD, base_time, base_time - $urandom_range(1, 50),
                   pick_key());
        end else begin
          push_cmd(dsaq_pkg::OP_ADD, base_time, base_time + $urandom_range(0, 60),
                   pick_key());
        end
      end else if (pick < 87) begin
        push_cmd(dsaq_pkg::OP_KILL, $urandom(), $urandom(), pick_key());
      end else if (pick < 96) begin
        // advance time slowly while filling, in bigger steps while draining
        base_time = base_time + (fill_phase ? $urandom_range(0, 3)
                                            : $urandom_range(0, 70));
        push_cmd(dsaq_pkg::OP_TICK, base_time, $urandom(), KEY_BITS'($urandom()));
      end else if (pick < 98) begin
        push_cmd(OP_UNUSED, $urandom(), $urandom(), KEY_BITS'($urandom()));
      end else begin
        // raw noise across the time and key fields, with a valid opcode
        push_cmd(2'($urandom_range(0, 2)), $urandom(), $urandom(),
                 KEY_BITS'($urandom()));
      end
    end

    // ---- reset, then let the driver run ----
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every command to go in and every owed result to come out
    @(posedge clk);
    while (cmd_q.size() != 0 || start || owed_q.size() != 0) @(posedge clk);
    // allow a trailing extra result to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && owed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: deadline_sorted_alarm_queue_top.f
rtl/dsaq_pkg.sv
rtl/dsaq_ctrl.sv
rtl/dsaq_dp.sv
rtl/deadline_sorted_alarm_queue_top.sv
rtl/dsaq_checker.sv
bench/deadline_sorted_alarm_queue_top_tb.sv
